/* src/mexp_pkg.sv */
// Package for the modular exponentiation core: payload types, unit handshake types and states.
package mexp_pkg;

   localparam int WORD_BITS     = 32;
   localparam int EXP_WIDTH     = 64;
   localparam int SCAN_BITS     = 32;
   localparam int SCAN_CNT_BITS = 5;

   localparam logic [SCAN_CNT_BITS-1:0] SCAN_LAST = SCAN_CNT_BITS'(SCAN_BITS - 1);

   typedef struct packed {
      logic [WORD_BITS-1:0] base;
      logic [EXP_WIDTH-1:0] exponent;
      logic [WORD_BITS-1:0] modulus;
   } mexp_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] power_mod;
      logic                 zero_modulus;
   } mexp_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] addend;
      logic [SCAN_BITS-1:0] multiplier;
   } mm_req_type;

   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] result;
   } mm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_EVAL,
      ST_MULT,
      ST_SQUARE,
      ST_DONE
   } mexp_state_type;

endpackage

/* src/mexp_mulmod.sv */
// Bit-serial modular multiplier: addend * multiplier mod modulus, one multiplier bit a cycle.
module mexp_mulmod #(
   parameter int MOD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mexp_pkg::mm_req_type mm_req,
   input  logic [MOD_BITS-1:0]  modulus,
   output mexp_pkg::mm_rsp_type mm_rsp
);
   import mexp_pkg::*;

   localparam int W = MOD_BITS + 2;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [SCAN_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SCAN_BITS-1:0]     mult_ff, mult_in;
   logic [MOD_BITS-1:0]      addend_ff, addend_in;
   logic [MOD_BITS-1:0]      rem_ff, rem_in;

   logic [W-1:0]        sum;
   logic [W-1:0]        mod1;
   logic [W-1:0]        mod2;
   logic [W-1:0]        diff1;
   logic [W-1:0]        diff2;
   logic [MOD_BITS-1:0] step;

   // The remainder stays below the modulus and so does the addend, so the
   // doubled sum is below three times the modulus: at most two subtractions.
   always_comb begin
      sum   = W'({rem_ff, 1'b0}) + (mult_ff[SCAN_BITS-1] ? W'(addend_ff) : '0);
      mod1  = W'(modulus);
      mod2  = {mod1[W-2:0], 1'b0};
      diff1 = sum - mod1;
      diff2 = sum - mod2;
      if (sum >= mod2) begin
         step = diff2[MOD_BITS-1:0];
      end else if (sum >= mod1) begin
         step = diff1[MOD_BITS-1:0];
      end else begin
         step = sum[MOD_BITS-1:0];
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mult_in   = mult_ff;
      addend_in = addend_ff;
      rem_in    = rem_ff;
      if (mm_req.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mult_in   = mm_req.multiplier;
         addend_in = mm_req.addend[MOD_BITS-1:0];
         rem_in    = '0;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + 1'b1;
         mult_in = {mult_ff[SCAN_BITS-2:0], 1'b0};
         rem_in  = step;
         if (cnt_ff == SCAN_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mult_ff   <= mult_in;
      addend_ff <= addend_in;
      rem_ff    <= rem_in;
   end

   assign mm_rsp.done   = done_ff;
   assign mm_rsp.result = WORD_BITS'(rem_ff);

endmodule

/* src/modular_exponentiation_core.sv */
// Top level of the modular exponentiation core: sequencer around a shared modular multiplier.
// Each item is a base reduction, then multiply and square passes of the serial multiplier,
// one multiply pass per set exponent bit; a zero modulus skips every pass.
// One item at a time: busy covers it all, and the next beat can be taken in the cycle after
// the result beat. Synchronous active-high reset returns the sequencer to idle with no
// result pending.
module modular_exponentiation_core #(
   parameter int EXP_BITS = 64,
   parameter int MOD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mexp_pkg::mexp_req_type req_data,
   output logic                   rsp_valid,
   output mexp_pkg::mexp_rsp_type rsp_data
);
   import mexp_pkg::*;

   mexp_state_type      state_ff, state_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic                zero_ff, zero_in;

   logic                accept;
   logic [MOD_BITS-1:0] req_mod;
   logic [EXP_BITS-1:0] req_exp;
   logic [EXP_BITS-1:0] exp_rest;
   logic [MOD_BITS-1:0] one_mod;
   logic [MOD_BITS-1:0] unit_result;
   mm_req_type          mm_req;
   mm_rsp_type          mm_rsp;

   // A beat is taken when start is high while the core is idle. Only the low
   // EXP_BITS exponent bits and MOD_BITS modulus bits take part.
   assign accept      = start && !busy;
   assign req_mod     = req_data.modulus[MOD_BITS-1:0];
   assign req_exp     = req_data.exponent[EXP_BITS-1:0];
   assign exp_rest    = exp_ff >> 1;
   assign one_mod     = (req_mod == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
   assign unit_result = mm_rsp.result[MOD_BITS-1:0];

   // The exponent is scanned from its low end. Once the remaining bits are all
   // zero the accumulator cannot change, so the sequencer finishes early.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_mod == '0) ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mm_rsp.done) begin
               state_in = (exp_rest == '0) ? ST_DONE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               state_in = ST_EVAL;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the shared multiplier. The addend operand must already be a
   // residue; the scanned operand may be any 32-bit value, which is how the
   // base itself is reduced: it is multiplied by one.
   always_comb begin
      mm_req.start      = 1'b0;
      mm_req.addend     = WORD_BITS'(sq_ff);
      mm_req.multiplier = SCAN_BITS'(sq_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mod != '0)) begin
               mm_req.start      = 1'b1;
               mm_req.addend     = WORD_BITS'(one_mod);
               mm_req.multiplier = req_data.base;
            end
         end
         ST_EVAL: begin
            if (exp_ff != '0) begin
               mm_req.start = 1'b1;
               if (exp_ff[0]) begin
                  mm_req.addend = WORD_BITS'(acc_ff);
               end
            end
         end
         ST_MULT: begin
            if (mm_rsp.done && (exp_rest != '0)) begin
               mm_req.start = 1'b1;
            end
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   // Operand registers follow the multiplier results.
   always_comb begin
      exp_in  = exp_ff;
      mod_in  = mod_ff;
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      zero_in = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in  = req_exp;
               mod_in  = req_mod;
               zero_in = (req_mod == '0);
               acc_in  = (req_mod == '0) ? '0 : one_mod;
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               sq_in = unit_result;
            end
         end
         ST_MULT: begin
            if (mm_rsp.done) begin
               acc_in = unit_result;
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               sq_in  = unit_result;
               exp_in = exp_rest;
            end
         end
         default: begin
            exp_in = exp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      mod_ff  <= mod_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      zero_ff <= zero_in;
   end

   // The result beat is shown for the single cycle spent in the done state.
   always_comb begin
      busy                  = (state_ff != ST_IDLE);
      rsp_valid             = (state_ff == ST_DONE);
      rsp_data.power_mod    = WORD_BITS'(acc_ff);
      rsp_data.zero_modulus = zero_ff;
   end

   mexp_mulmod #(
      .MOD_BITS(MOD_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .modulus(mod_ff),
      .mm_rsp (mm_rsp)
   );

endmodule

/* src/mexp_checker.sv */
// Port-level checker for the modular exponentiation core, bound to the top level.
module mexp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input mexp_pkg::mexp_req_type req_data,
   input logic                   rsp_valid,
   input mexp_pkg::mexp_rsp_type rsp_data
);
   import mexp_pkg::*;

   // An accepted beat makes the core busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after an accepted beat");

   // A result beat is shown while the item is still in flight.
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   // After a result beat the core is idle again, so no second beat follows.
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("core still busy after its result beat");

   // A zero modulus always reports a zero power.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_modulus) |-> (rsp_data.power_mod == '0))
      else $error("nonzero power with zero modulus");

   // A zero modulus item answers in the cycle right after it is taken.
   a_zero_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.modulus == '0)) |=> rsp_valid)
      else $error("zero modulus not answered promptly");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
